// ===== rtl/smd_pkg.sv =====
// shared constants, codes and controller/datapath types for the splitmix draw block
// no dependencies
package smd_pkg;

  localparam int unsigned MaxWidthDef = 256;
  localparam int unsigned WordBits    = 64;
  localparam int unsigned DivSteps    = 64;

  localparam logic [63:0] Gamma = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] Mix1  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] Mix2  = 64'h94d0_49bb_1331_11eb;

  localparam int unsigned Shift1 = 30;
  localparam int unsigned Shift2 = 27;
  localparam int unsigned Shift3 = 31;

  typedef enum logic [1:0] {
    MODE_SEED = 2'd0,
    MODE_ARB  = 2'd1,
    MODE_DOM  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    DP_NOP    = 4'd0,
    DP_LOAD   = 4'd1,
    DP_ADV    = 4'd2,
    DP_MUL_LO = 4'd3,
    DP_MUL_HL = 4'd4,
    DP_MUL_LH = 4'd5,
    DP_XS     = 4'd6,
    DP_FIN    = 4'd7,
    DP_DIV    = 4'd8,
    DP_NEXT   = 4'd9
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   use_c2;
  } dp_cmd_t;

  typedef struct packed {
    mode_e in_mode;
    logic  in_empty;
    logic  dom;
    logic  last_word;
    logic  div_last;
  } dp_sts_t;

endpackage

// ===== rtl/smd_if.sv =====
// valid/ready channel interfaces for draw requests and drawn words
// no dependencies
interface smd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] seed;
  logic [8:0]  bit_width;
  logic [31:0] domain_size;

  modport source (output valid, mode, seed, bit_width, domain_size, input ready);
  modport sink (input valid, mode, seed, bit_width, domain_size, output ready);
endinterface

interface smd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [1:0]  word_index;
  logic        last;
  logic        kind;

  modport source (output valid, value, word_index, last, kind, input ready);
  modport sink (input valid, value, word_index, last, kind, output ready);
endinterface

// ===== rtl/smd_datapath.sv =====
// datapath: generator state, shared 32x32 multiplier, masking and bit-serial remainder
// depends on smd_pkg
module smd_datapath import smd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  logic [1:0]  mode_i,
  input  logic [63:0] seed_i,
  input  logic [8:0]  bit_width_i,
  input  logic [31:0] domain_size_i,
  output logic [63:0] value_o,
  output logic [1:0]  word_index_o,
  output logic        last_o,
  output logic        kind_o
);

  localparam int unsigned EffMax   = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
  localparam int unsigned MaxWords = (EffMax + 63) / 64;
  localparam int unsigned CntW     = $clog2(MaxWords + 1);
  localparam int unsigned DivW     = $clog2(DivSteps);
  localparam logic [8:0]  EffMaxW  = 9'(EffMax);

  logic [63:0]     gen_q, gen_d;
  logic [63:0]     acc_q, acc_d;
  logic [63:0]     v_q, v_d;
  logic [63:0]     quo_q, quo_d;
  logic [32:0]     rem_q, rem_d;
  logic [63:0]     res_q, res_d;
  logic [31:0]     dsize_q, dsize_d;
  logic [5:0]      wrem_q, wrem_d;
  logic            kind_q, kind_d;
  logic [CntW-1:0] words_q, words_d;
  logic [1:0]      widx_q, widx_d;
  logic [DivW-1:0] dcnt_q, dcnt_d;

  logic [8:0]      eff_w;
  logic [CntW-1:0] in_words;
  logic [63:0]     cmul;
  logic [31:0]     ma, mb;
  logic [63:0]     prod;
  logic [63:0]     adv_s;
  logic [63:0]     fin_r;
  logic [63:0]     mask;
  logic [32:0]     trial;
  logic [32:0]     dsz_ext;
  logic            is_last;

  // saturate requested width
  assign eff_w    = (bit_width_i > EffMaxW) ? EffMaxW : bit_width_i;
  assign in_words = CntW'(eff_w[8:6]) + CntW'(|eff_w[5:0]);

  assign cmul = cmd_i.use_c2 ? Mix2 : Mix1;

  always_comb begin
    unique case (cmd_i.op)
      DP_MUL_HL: begin
        ma = v_q[63:32];
        mb = cmul[31:0];
      end
      DP_MUL_LH: begin
        ma = v_q[31:0];
        mb = cmul[63:32];
      end
      default: begin
        ma = v_q[31:0];
        mb = cmul[31:0];
      end
    endcase
  end

  assign prod    = {32'b0, ma} * {32'b0, mb};
  assign adv_s   = gen_q + Gamma;
  assign fin_r   = acc_q ^ (acc_q >> Shift3);
  assign is_last = (words_q == CntW'(1));
  assign mask    = (is_last && (wrem_q != 6'd0)) ? ((64'd1 << wrem_q) - 64'd1) : '1;
  assign trial   = {rem_q[31:0], quo_q[63]};
  assign dsz_ext = {1'b0, dsize_q};

  always_comb begin
    gen_d   = gen_q;
    acc_d   = acc_q;
    v_d     = v_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    res_d   = res_q;
    dsize_d = dsize_q;
    wrem_d  = wrem_q;
    kind_d  = kind_q;
    words_d = words_q;
    widx_d  = widx_q;
    dcnt_d  = dcnt_q;
    unique case (cmd_i.op)
      DP_NOP: begin
      end
      DP_LOAD: begin
        if (mode_e'(mode_i) == MODE_SEED) begin
          gen_d = seed_i;
        end
        kind_d  = (mode_e'(mode_i) == MODE_DOM);
        dsize_d = domain_size_i;
        wrem_d  = eff_w[5:0];
        words_d = in_words;
        widx_d  = 2'd0;
      end
      DP_ADV: begin
        gen_d = adv_s;
        v_d   = adv_s ^ (adv_s >> Shift1);
      end
      DP_MUL_LO: begin
        acc_d = prod;
      end
      DP_MUL_HL, DP_MUL_LH: begin
        acc_d = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
      end
      DP_XS: begin
        v_d = acc_q ^ (acc_q >> Shift2);
      end
      DP_FIN: begin
        res_d  = fin_r & mask;
        quo_d  = fin_r;
        rem_d  = '0;
        dcnt_d = '0;
      end
      DP_DIV: begin
        rem_d  = (trial >= dsz_ext) ? (trial - dsz_ext) : trial;
        quo_d  = {quo_q[62:0], 1'b0};
        dcnt_d = dcnt_q + DivW'(1);
      end
      DP_NEXT: begin
        words_d = words_q - CntW'(1);
        widx_d  = widx_q + 2'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q   <= '0;
      kind_q  <= 1'b0;
      words_q <= '0;
      widx_q  <= '0;
      dcnt_q  <= '0;
    end else begin
      gen_q   <= gen_d;
      kind_q  <= kind_d;
      words_q <= words_d;
      widx_q  <= widx_d;
      dcnt_q  <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    v_q     <= v_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    res_q   <= res_d;
    dsize_q <= dsize_d;
    wrem_q  <= wrem_d;
  end

  assign value_o      = kind_q ? ((dsize_q == 32'd0) ? 64'd0 : {32'b0, rem_q[31:0]}) : res_q;
  assign word_index_o = widx_q;
  assign last_o       = kind_q | is_last;
  assign kind_o       = kind_q;

  assign sts_o.in_mode   = mode_e'(mode_i);
  assign sts_o.in_empty  = (eff_w == 9'd0);
  assign sts_o.dom       = kind_q;
  assign sts_o.last_word = kind_q | is_last;
  assign sts_o.div_last  = (dcnt_q == DivW'(DivSteps - 1));

endmodule

// ===== rtl/smd_ctrl.sv =====
// controller: sequences one generator step per word, the remainder loop and the handshakes
// depends on smd_pkg
module smd_ctrl import smd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE = 12'h001,
    S_ADV  = 12'h002,
    S_M1A  = 12'h004,
    S_M1B  = 12'h008,
    S_M1C  = 12'h010,
    S_XS   = 12'h020,
    S_M2A  = 12'h040,
    S_M2B  = 12'h080,
    S_M2C  = 12'h100,
    S_FIN  = 12'h200,
    S_DIV  = 12'h400,
    S_OUT  = 12'h800
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o.op     = DP_NOP;
    cmd_o.use_c2 = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          if ((sts_i.in_mode == MODE_ARB && !sts_i.in_empty) ||
              sts_i.in_mode == MODE_DOM) begin
            state_d = S_ADV;
          end
        end
      end
      S_ADV: begin
        cmd_o.op = DP_ADV;
        state_d  = S_M1A;
      end
      S_M1A: begin
        cmd_o.op = DP_MUL_LO;
        state_d  = S_M1B;
      end
      S_M1B: begin
        cmd_o.op = DP_MUL_HL;
        state_d  = S_M1C;
      end
      S_M1C: begin
        cmd_o.op = DP_MUL_LH;
        state_d  = S_XS;
      end
      S_XS: begin
        cmd_o.op = DP_XS;
        state_d  = S_M2A;
      end
      S_M2A: begin
        cmd_o.op     = DP_MUL_LO;
        cmd_o.use_c2 = 1'b1;
        state_d      = S_M2B;
      end
      S_M2B: begin
        cmd_o.op     = DP_MUL_HL;
        cmd_o.use_c2 = 1'b1;
        state_d      = S_M2C;
      end
      S_M2C: begin
        cmd_o.op     = DP_MUL_LH;
        cmd_o.use_c2 = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        cmd_o.op = DP_FIN;
        state_d  = sts_i.dom ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd_o.op = DP_DIV;
        if (sts_i.div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.last_word) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.op = DP_NEXT;
            state_d  = S_ADV;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/splitmix_random_value_draw.sv =====
// splitmix64 draw block: seed load, arbitrary-width word draw, domain index draw
// sequencing: seed load in the idle state; arbitrary draw runs one generator step per word
// (through the shared 32x32 multiplier, three passes per 64-bit product) plus output stall
// domain draw: one generator step, then the one-bit-per-cycle remainder loop
// one item at a time; the next item is taken after the last beat of the current one
// reset: async active low, generator state cleared to zero, controller idle
// depends on smd_pkg, smd_if, smd_ctrl, smd_datapath
module splitmix_random_value_draw import smd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  smd_in_if.sink     in_i,
  smd_out_if.source  out_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  smd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  smd_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (in_i.mode),
    .seed_i        (in_i.seed),
    .bit_width_i   (in_i.bit_width),
    .domain_size_i (in_i.domain_size),
    .value_o       (out_o.value),
    .word_index_o  (out_o.word_index),
    .last_o        (out_o.last),
    .kind_o        (out_o.kind)
  );

endmodule

// ===== rtl/smd_checker.sv =====
// port-level checks for the splitmix draw block, bound to the top level
// depends on splitmix_random_value_draw
module smd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_value_i,
  input logic [1:0]  out_word_index_i,
  input logic        out_last_i,
  input logic        out_kind_i
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) &&
      $stable(out_last_i))
    else $error("stalled output beat changed");

  // one item in flight
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input taken while a result is pending");

  // domain index is a single beat
  a_dom_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i |-> out_last_i && out_word_index_i == 2'd0)
    else $error("domain result not a single last beat");

  // more words follow a non-last beat
  a_busy_after_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> !in_ready_i)
    else $error("block idle before last word");

  // no beat offered while a request is taken
  a_in_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i)
    else $error("input accepted during output beat");

endmodule

bind splitmix_random_value_draw smd_checker u_smd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_value_i      (out_o.value),
  .out_word_index_i (out_o.word_index),
  .out_last_i       (out_o.last),
  .out_kind_i       (out_o.kind)
);

// ===== test/tb_splitmix_random_value_draw.sv =====
`timescale 1ns / 100ps
// self-checking bench for splitmix_random_value_draw: directed table, then random requests,
// every output beat compared against a local splitmix64 predictor with random stalls
// depends on smd_pkg, smd_if and the splitmix_random_value_draw rtl
module tb_splitmix_random_value_draw;
  import smd_pkg::*;

  localparam int unsigned MaxW        = MaxWidthDef;
  localparam int          RandItems   = 240;
  localparam int          StallLimit  = 2000;
  localparam int          DrainCycles = 100;
  localparam int          MaxReports  = 10;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  word_index;
    logic        last;
    logic        kind;
  } draw_beat_t;

  typedef struct {
    mode_e       mode;
    logic [63:0] seed;
    logic [8:0]  width;
    logic [31:0] dsize;
    int          fixed_n;
    logic [63:0] fixed_val;
  } req_row_t;

  logic clk;
  logic rst_ni;

  smd_in_if  req_if ();
  smd_out_if draw_if ();

  splitmix_random_value_draw uut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (draw_if)
  );

  logic [63:0] gen_q;
  draw_beat_t  pending_beats[$];
  req_row_t    dir_rows[$];
  int          err_cnt;
  int          idle_cnt;
  int          in_calm;
  int          out_calm;
  int          req_fixed_n;
  logic [63:0] req_fixed_val;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] splitmix_next();
    logic [63:0] z;
    gen_q = gen_q + Gamma;
    z = gen_q;
    z = (z ^ (z >> Shift1)) * Mix1;
    z = (z ^ (z >> Shift2)) * Mix2;
    return z ^ (z >> Shift3);
  endfunction

  task automatic predict_draw(input mode_e mode, input logic [63:0] seed,
                              input logic [8:0] width, input logic [31:0] dsize,
                              input int fixed_n, input logic [63:0] fixed_val);
    draw_beat_t  beat;
    logic [63:0] word;
    int unsigned w;
    int unsigned nwords;
    int unsigned rem;
    w = width;
    if (w > MaxW) w = MaxW;
    case (mode)
      MODE_SEED: begin
        gen_q = seed;
      end
      MODE_ARB: begin
        if (w != 0) begin
          nwords = (w + 63) / 64;
          rem = w % 64;
          for (int unsigned k = 0; k < nwords; k++) begin
            word = splitmix_next();
            if (k + 1 == nwords && rem != 0) word = word & ((64'd1 << rem) - 64'd1);
            beat.value = word;
            beat.word_index = k[1:0];
            beat.last = (k + 1 == nwords);
            beat.kind = 1'b0;
            if (fixed_n < 0) pending_beats.insert(pending_beats.size(), beat);
          end
        end
      end
      MODE_DOM: begin
        word = splitmix_next();
        beat.value = (dsize != 32'd0) ? (word % {32'd0, dsize}) : 64'd0;
        beat.word_index = 2'd0;
        beat.last = 1'b1;
        beat.kind = 1'b1;
        if (fixed_n < 0) pending_beats.insert(pending_beats.size(), beat);
      end
      default: ;
    endcase
    if (fixed_n > 0) begin
      beat.value = fixed_val;
      beat.word_index = 2'd0;
      beat.last = 1'b1;
      beat.kind = 1'b1;
      pending_beats.insert(pending_beats.size(), beat);
    end
  endtask

  task automatic check_beat();
    draw_beat_t want;
    if (pending_beats.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MaxReports)
        $display("unexpected beat: value=%h idx=%0d last=%b kind=%b", draw_if.value,
                 draw_if.word_index, draw_if.last, draw_if.kind);
    end else begin
      want = pending_beats.pop_front();
      if (draw_if.value !== want.value || draw_if.word_index !== want.word_index ||
          draw_if.last !== want.last || draw_if.kind !== want.kind) begin
        err_cnt++;
        if (err_cnt <= MaxReports) begin
          $display("beat mismatch: exp value=%h idx=%0d last=%b kind=%b",
                   want.value, want.word_index, want.last, want.kind);
          $display("               got value=%h idx=%0d last=%b kind=%b",
                   draw_if.value, draw_if.word_index, draw_if.last, draw_if.kind);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_ni) begin
      if (draw_if.valid && draw_if.ready) check_beat();
      if (req_if.valid && req_if.ready)
        predict_draw(mode_e'(req_if.mode), req_if.seed, req_if.bit_width, req_if.domain_size,
                     req_fixed_n, req_fixed_val);
    end
  end

  always @(posedge clk) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (draw_if.valid && draw_if.ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt == StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // mostly random waits, with runs of back-to-back beats
  task automatic pick_wait(inout int calm, output int cycles);
    if (calm > 0) begin
      calm = calm - 1;
      cycles = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(4, 24);
      cycles = 0;
    end else begin
      cycles = $urandom_range(0, 18);
    end
  endtask

  function automatic req_row_t mk_row(mode_e mode, logic [63:0] seed, logic [8:0] width,
                                      logic [31:0] dsize, int fixed_n, logic [63:0] fixed_val);
    req_row_t r;
    r.mode = mode;
    r.seed = seed;
    r.width = width;
    r.dsize = dsize;
    r.fixed_n = fixed_n;
    r.fixed_val = fixed_val;
    return r;
  endfunction

  task automatic add_row(input mode_e mode, input logic [63:0] seed, input logic [8:0] width,
                         input logic [31:0] dsize, input int fixed_n,
                         input logic [63:0] fixed_val);
    dir_rows.insert(dir_rows.size(), mk_row(mode, seed, width, dsize, fixed_n, fixed_val));
  endtask

  task automatic make_random_req(output req_row_t r);
    int sel;
    int wsel;
    int dsel;
    sel = $urandom_range(0, 99);
    wsel = $urandom_range(0, 9);
    dsel = $urandom_range(0, 19);
    r.seed = {$urandom, $urandom};
    r.width = 9'($urandom);
    r.dsize = $urandom;
    r.fixed_n = -1;
    r.fixed_val = 64'd0;
    if (sel < 8) r.mode = MODE_SEED;
    else if (sel < 12) r.mode = MODE_NONE;
    else if (sel < 58) r.mode = MODE_ARB;
    else r.mode = MODE_DOM;
    if (wsel < 6) r.width = 9'($urandom_range(1, 64));
    else if (wsel < 9) r.width = 9'($urandom_range(1, MaxW));
    if (dsel < 8) r.dsize = $urandom_range(1, 16);
    else if (dsel < 12) r.dsize = 32'd1 << $urandom_range(0, 31);
    else if (dsel == 12) r.dsize = 32'd0;
  endtask

  task automatic send_req(input req_row_t r);
    int gap;
    pick_wait(in_calm, gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.mode        <= r.mode;
    req_if.seed        <= r.seed;
    req_if.bit_width   <= r.width;
    req_if.domain_size <= r.dsize;
    req_fixed_n        <= r.fixed_n;
    req_fixed_val      <= r.fixed_val;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // output side: random back-pressure per beat
  initial begin
    int stall;
    draw_if.ready = 1'b0;
    do @(posedge clk); while (!rst_ni);
    forever begin
      pick_wait(out_calm, stall);
      if (stall > 0) begin
        draw_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      draw_if.ready <= 1'b1;
      do @(posedge clk); while (!draw_if.valid);
    end
  end

  initial begin
    req_row_t r;
    int       drawn;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.mode = MODE_SEED;
    req_if.seed = 64'd0;
    req_if.bit_width = 9'd0;
    req_if.domain_size = 32'd0;
    req_fixed_n = -1;
    req_fixed_val = 64'd0;
    gen_q = 64'd0;
    err_cnt = 0;
    idle_cnt = 0;
    in_calm = 0;
    out_calm = 0;
    drawn = 0;

    add_row(MODE_ARB,  '0, 9'd64,   '1, -1, '0);
    add_row(MODE_DOM,  '1, 9'd0,    32'd1, 1, 64'd0);
    add_row(MODE_DOM,  '0, 9'h1FF,  32'd0, 1, 64'd0);
    add_row(MODE_DOM,  '0, 9'd0,    32'hFFFF_FFFF, -1, '0);
    add_row(MODE_ARB,  '1, 9'd1,    '0, -1, '0);
    add_row(MODE_ARB,  '0, 9'd256,  '1, -1, '0);
    add_row(MODE_ARB,  '1, 9'h1FF,  '0, -1, '0);
    add_row(MODE_ARB,  '1, 9'd0,    '1, 0, '0);
    add_row(MODE_NONE, '1, 9'd64,   '1, 0, '0);
    add_row(MODE_SEED, '0, 9'h1FF,  '1, 0, '0);
    add_row(MODE_ARB,  '0, 9'd65,   '0, -1, '0);
    add_row(MODE_SEED, '1, 9'd0,    '0, 0, '0);
    add_row(MODE_ARB,  '0, 9'd128,  '0, -1, '0);
    add_row(MODE_DOM,  '0, 9'd0,    32'd2, -1, '0);
    add_row(MODE_SEED, 64'hAAAA_AAAA_AAAA_AAAA, 9'h0AA, 32'hAAAA_AAAA, 0, '0);
    add_row(MODE_ARB,  '0, 9'd63,   '0, -1, '0);
    add_row(MODE_ARB,  '0, 9'd192,  '0, -1, '0);
    add_row(MODE_SEED, 64'h5555_5555_5555_5555, 9'h155, 32'h5555_5555, 0, '0);
    add_row(MODE_DOM,  '0, 9'd0,    32'h8000_0000, -1, '0);
    add_row(MODE_ARB,  '0, 9'd257,  '0, -1, '0);
    add_row(MODE_DOM,  '0, 9'd0,    32'hFFFF_FFFE, -1, '0);
    add_row(MODE_ARB,  '0, 9'd200,  '0, -1, '0);

    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_req(dir_rows[i]);

    while (drawn < RandItems) begin
      make_random_req(r);
      send_req(r);
      if (!(r.mode == MODE_NONE || (r.mode == MODE_ARB && r.width == 9'd0))) drawn++;
    end
    req_if.valid <= 1'b0;

    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (err_cnt == 0 && pending_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== splitmix_random_value_draw.f =====
rtl/smd_pkg.sv
rtl/smd_if.sv
rtl/smd_datapath.sv
rtl/smd_ctrl.sv
rtl/splitmix_random_value_draw.sv
rtl/smd_checker.sv
test/tb_splitmix_random_value_draw.sv
